// File: design/led_strip_frame_builder_assert.svh
// ----------------------------------------------------------------------------
// led strip frame builder assertion macros
// concurrent assertion helpers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_FRAME_BUILDER_ASSERT_SVH
`define LED_STRIP_FRAME_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define LSFB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// expression must never be true outside reset
`define LSFB_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`else

`define LSFB_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSFB_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: design/lsfb_pkg.sv
// ----------------------------------------------------------------------------
// lsfb_pkg
// shared types and constants of the led strip frame builder
// ----------------------------------------------------------------------------
package lsfb_pkg;

	localparam int MAX_LEDS_DEFAULT    = 64;
	localparam int QUEUE_DEPTH_DEFAULT = 2;

	localparam int COLOUR_W = 24;
	localparam int COUNT_W  = 7;
	localparam int STOP_W   = 4;
	localparam int IDX_W    = 4;
	localparam int BYTE_W   = 8;

	localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_FF   = 8'hff;

	localparam logic [IDX_W-1:0] START_BYTES = 4'd4;
	localparam logic [IDX_W-1:0] LED_BYTES   = 4'd4;

	// one stop byte per 16 leds, rounded up
	localparam logic [BYTE_W-1:0] STOP_ROUND = 8'd15;
	localparam int                STOP_SHIFT = 4;

	typedef enum logic [1:0] {
		LED_HEADER = 2'd0,
		LED_LOW    = 2'd1,
		LED_MID    = 2'd2,
		LED_HIGH   = 2'd3
	} led_byte_t;

	typedef struct packed {
		logic                start;
		logic                is_led;
		logic [COLOUR_W-1:0] colour;
		logic [STOP_W-1:0]   stops;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic valid;
	} queue_status_t;

endpackage

// File: design/lsfb_front.sv
// ----------------------------------------------------------------------------
// lsfb_front
// accepts items; while enabled, tracks the frame and turns each into a command
// ----------------------------------------------------------------------------
`include "led_strip_frame_builder_assert.svh"

module lsfb_front #(
	parameter int MAX_LEDS = lsfb_pkg::MAX_LEDS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          enable,
	input  logic                          accept,
	input  logic                          mode,
	input  logic [lsfb_pkg::COLOUR_W-1:0] set_colour,
	input  logic [lsfb_pkg::COLOUR_W-1:0] pressed_colour,
	input  logic                          button_pressed,
	output logic                          push,
	output lsfb_pkg::cmd_t                cmd
);

	localparam logic [lsfb_pkg::COUNT_W-1:0] COUNT_MAX = lsfb_pkg::COUNT_W'(MAX_LEDS);

	logic                         in_frame_q;
	logic [lsfb_pkg::COUNT_W-1:0] led_count_q;
	logic [lsfb_pkg::BYTE_W-1:0]  stop_sum;
	logic [lsfb_pkg::STOP_W-1:0]  stops;
	logic                         has_bytes;

	assign stop_sum = lsfb_pkg::BYTE_W'(led_count_q) + lsfb_pkg::STOP_ROUND;
	assign stops    = stop_sum[lsfb_pkg::STOP_SHIFT +: lsfb_pkg::STOP_W];

	always_comb begin
		cmd.start  = !in_frame_q;
		cmd.is_led = !mode;
		cmd.colour = ((set_colour == '0) && button_pressed) ? pressed_colour : set_colour;
		cmd.stops  = mode ? stops : '0;
	end

	assign has_bytes = cmd.start || cmd.is_led || (cmd.stops != '0);
	assign push      = accept && enable && has_bytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			led_count_q <= '0;
		end else if (accept && enable) begin
			if (!mode) begin
				in_frame_q <= 1'b1;
				if (led_count_q < COUNT_MAX) begin
					led_count_q <= led_count_q + lsfb_pkg::COUNT_W'(1);
				end
			end else begin
				in_frame_q  <= 1'b0;
				led_count_q <= '0;
			end
		end
	end

	`LSFB_ASSERT(a_count_bound, clk, arst_n, led_count_q <= COUNT_MAX, "led count above limit")
	`LSFB_ASSERT(a_idle_count, clk, arst_n, !in_frame_q |-> led_count_q == '0, "count outside frame")

endmodule

// File: design/lsfb_queue.sv
// ----------------------------------------------------------------------------
// lsfb_queue
// short command queue between the front and the byte sequencer
// ----------------------------------------------------------------------------
`include "led_strip_frame_builder_assert.svh"

module lsfb_queue #(
	parameter int DEPTH = lsfb_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  lsfb_pkg::cmd_t         push_cmd,
	input  logic                   pop,
	output lsfb_pkg::cmd_t         head,
	output lsfb_pkg::queue_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lsfb_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.valid = (count_q != '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`LSFB_NEVER(a_no_overflow, clk, arst_n, push && status.full, "push into full queue")
	`LSFB_NEVER(a_no_underflow, clk, arst_n, pop && !status.valid, "pop from empty queue")

endmodule

// File: design/lsfb_back.sv
// ----------------------------------------------------------------------------
// lsfb_back
// byte sequencer: walks the head command and drives the output register
// ----------------------------------------------------------------------------
`include "led_strip_frame_builder_assert.svh"

module lsfb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lsfb_pkg::cmd_t              head,
	input  logic                        head_valid,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [lsfb_pkg::BYTE_W-1:0] m_tdata,
	output logic                        m_tlast
);

	logic [lsfb_pkg::IDX_W-1:0]  idx_q;
	logic                        valid_q;
	logic [lsfb_pkg::BYTE_W-1:0] data_q;
	logic                        last_q;

	logic [lsfb_pkg::IDX_W-1:0]  start_len;
	logic [lsfb_pkg::IDX_W-1:0]  body_len;
	logic [lsfb_pkg::IDX_W-1:0]  cmd_len;
	logic [lsfb_pkg::IDX_W-1:0]  body_idx;
	logic                        load;
	logic                        last_now;
	logic [lsfb_pkg::BYTE_W-1:0] byte_now;

	assign start_len = head.start ? lsfb_pkg::START_BYTES : '0;
	assign body_len  = head.is_led ? lsfb_pkg::LED_BYTES : lsfb_pkg::IDX_W'(head.stops);
	assign cmd_len   = start_len + body_len;
	assign body_idx  = idx_q - start_len;
	assign last_now  = (idx_q == cmd_len - lsfb_pkg::IDX_W'(1));

	// output register takes a new byte when empty or being drained
	assign load = !valid_q || m_tready;
	assign pop  = load && head_valid && last_now;

	always_comb begin
		if (idx_q < start_len) begin
			byte_now = lsfb_pkg::BYTE_ZERO;
		end else if (!head.is_led) begin
			byte_now = lsfb_pkg::BYTE_FF;
		end else begin
			case (lsfb_pkg::led_byte_t'(body_idx[1:0]))
				lsfb_pkg::LED_HEADER: byte_now = lsfb_pkg::BYTE_FF;
				lsfb_pkg::LED_LOW:    byte_now = head.colour[7:0];
				lsfb_pkg::LED_MID:    byte_now = head.colour[15:8];
				lsfb_pkg::LED_HIGH:   byte_now = head.colour[23:16];
				default:              byte_now = lsfb_pkg::BYTE_FF;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= last_now ? '0 : idx_q + lsfb_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			data_q <= byte_now;
			last_q <= last_now;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

	`LSFB_ASSERT(a_idx_needs_head, clk, arst_n, idx_q != '0 |-> head_valid, "command lost mid run")
	`LSFB_ASSERT(a_idx_in_range, clk, arst_n, head_valid |-> idx_q < cmd_len, "byte index past command")

endmodule

// File: design/led_strip_frame_builder.sv
// ----------------------------------------------------------------------------
// led_strip_frame_builder
// byte stream encoder for a two-wire addressable led strip
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tdata: led colours and button, tuser: mode
// m_*       out  m_tvalid/m_tready    tdata: out_byte, tlast: last_of_run
// cfg_*     in   cfg_we               cfg_wdata: strip_enable
//
// one output byte per cycle from the sequencer's output register while m_tready is high and a command is queued
// led item: 4 bytes, plus 4 start bytes on the first item of a frame
// frame end: ceil(count/16) stop bytes, or 4 start bytes with no frame open
// a QUEUE_DEPTH command queue lets input run ahead while m_tready is low
// reset clears the frame state and the queue, no clearing pass
// ----------------------------------------------------------------------------
module led_strip_frame_builder #(
	parameter int MAX_LEDS    = lsfb_pkg::MAX_LEDS_DEFAULT,
	parameter int QUEUE_DEPTH = lsfb_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// set_colour[23:0], pressed_colour[47:24], button_pressed[48], zero pad
	input  logic [55:0] s_tdata,
	// mode[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_byte[7:0]
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	logic                    strip_enable_q;
	logic                    accept;
	logic                    push;
	logic                    pop;
	lsfb_pkg::cmd_t          push_cmd;
	lsfb_pkg::cmd_t          head;
	lsfb_pkg::queue_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_enable_q <= 1'b0;
		end else if (cfg_we) begin
			strip_enable_q <= cfg_wdata;
		end
	end

	assign s_tready = !q_status.full;
	assign accept   = s_tvalid && s_tready;

	lsfb_front #(
		.MAX_LEDS(MAX_LEDS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.enable        (strip_enable_q),
		.accept        (accept),
		.mode          (s_tuser),
		.set_colour    (s_tdata[23:0]),
		.pressed_colour(s_tdata[47:24]),
		.button_pressed(s_tdata[48]),
		.push          (push),
		.cmd           (push_cmd)
	);

	lsfb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.status  (q_status)
	);

	lsfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(q_status.valid),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
